>>> rtl/core/qte_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: shared package
// This file holds the widths, constants, stage payload types and the
// arctangent table for the pipelined converter.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

  localparam int ANGLE_ITERATIONS = 14;
  localparam int MAX_STEPS = 24;
  localparam int CORDIC_STEPS =
    (ANGLE_ITERATIONS < MAX_STEPS) ? ANGLE_ITERATIONS : MAX_STEPS;

  localparam int QW = 16;
  localparam int PW = 32;
  localparam int SW = 34;
  localparam int TW = 29;
  localparam int SQ_N = 29;
  localparam int RW = 57;
  localparam int TRW = 59;
  localparam int PRE_SH = 16;
  localparam int CW = 53;
  localparam int ZW = 32;
  localparam int RNDW = 18;
  localparam int AXW = 15;
  localparam int AYW = 16;

  localparam int NST = 4 + SQ_N + 1 + CORDIC_STEPS + 1;

  localparam logic signed [ZW-1:0] PI_Q28 = 32'sd843314857;
  localparam logic signed [SW-1:0] ONE_Q28 = 34'sd268435456;
  localparam logic signed [RNDW-1:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [RNDW-1:0] PI_Q13 = 18'sd25736;
  localparam logic [RW-1:0] ONE_SQ = RW'(1) << (RW - 1);

  typedef struct packed {
    logic signed [SW-1:0] ya;
    logic signed [SW-1:0] xa;
    logic signed [SW-1:0] yb;
    logic signed [SW-1:0] xb;
    logic signed [TW-1:0] t;
    logic sat;
    logic sat_neg;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic zero;
  } cord_t;

  function automatic logic signed [ZW-1:0] atan_q28(input int unsigned idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0: r = 32'sd210828714;
      1: r = 32'sd124459457;
      2: r = 32'sd65760959;
      3: r = 32'sd33381290;
      4: r = 32'sd16755422;
      5: r = 32'sd8385879;
      6: r = 32'sd4193963;
      7: r = 32'sd2097109;
      8: r = 32'sd1048571;
      9: r = 32'sd524287;
      10: r = 32'sd262144;
      11: r = 32'sd131072;
      12: r = 32'sd65536;
      13: r = 32'sd32768;
      14: r = 32'sd16384;
      15: r = 32'sd8192;
      16: r = 32'sd4096;
      17: r = 32'sd2048;
      18: r = 32'sd1024;
      19: r = 32'sd512;
      20: r = 32'sd256;
      21: r = 32'sd128;
      22: r = 32'sd64;
      23: r = 32'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Folds the vector into the right half plane before the rotations start.
  function automatic cord_t cord_init(input logic signed [CW-1:0] y,
                                      input logic signed [CW-1:0] x);
    cord_t c;
    c.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      c.z = (y >= 0) ? PI_Q28 : -PI_Q28;
      c.x = -x;
      c.y = -y;
    end else begin
      c.z = '0;
      c.x = x;
      c.y = y;
    end
    return c;
  endfunction

  function automatic logic signed [RNDW-1:0] round_q13(
    input logic signed [ZW-1:0] z, input logic signed [RNDW-1:0] lim);
    logic signed [ZW:0] s;
    logic signed [RNDW-1:0] r;
    s = (ZW+1)'(z) + (ZW+1)'(16384);
    r = RNDW'(s >>> 15);
    if (r > lim) begin
      r = lim;
    end
    if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/qte_quat_if.sv
// ----------------------------------------------------------------------------
// Quaternion input channel
// A valid/ready channel that carries one Q1.14 quaternion per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface qte_quat_if;
  logic valid;
  logic ready;
  logic signed [qte_pkg::QW-1:0] quat_x;
  logic signed [qte_pkg::QW-1:0] quat_y;
  logic signed [qte_pkg::QW-1:0] quat_z;
  logic signed [qte_pkg::QW-1:0] quat_w;

  modport source(output valid, output quat_x, output quat_y, output quat_z,
                 output quat_w, input ready);
  modport sink(input valid, input quat_x, input quat_y, input quat_z,
               input quat_w, output ready);
endinterface

`default_nettype wire

>>> rtl/core/qte_angle_if.sv
// ----------------------------------------------------------------------------
// Euler angle result channel
// A valid/ready channel that carries angle_x in Q1.13 and two Q2.13 angles.
// ----------------------------------------------------------------------------
`default_nettype none

interface qte_angle_if;
  logic valid;
  logic ready;
  logic signed [qte_pkg::AXW-1:0] angle_x;
  logic signed [qte_pkg::AYW-1:0] angle_y;
  logic signed [qte_pkg::AYW-1:0] angle_z;

  modport source(output valid, output angle_x, output angle_y, output angle_z,
                 input ready);
  modport sink(input valid, input angle_x, input angle_y, input angle_z,
               output ready);
endinterface

`default_nettype wire

>>> rtl/core/quaternion_to_euler_angles_unit.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles converter
// Converts Q1.14 quaternions to Z/X/Y Euler radians: X in Q1.13, Y/Z in Q2.13.
// ----------------------------------------------------------------------------
// The unit takes one quaternion transaction per clock while the output is not
// stalled and returns one angle transaction per quaternion, in order. The
// pipeline has product, sum, square and difference stages, a 29-stage
// square root for the pitch arcsine, one fold stage, one CORDIC stage per
// iteration for the three arctangents and one rounding stage. When the
// output is stalled the whole pipeline holds and in_chan.ready drops.
`default_nettype none

module quaternion_to_euler_angles_unit (
  input  logic              clk,
  input  logic              rst_n,
  qte_quat_if.sink          in_chan,
  qte_angle_if.source       out_chan
);

  localparam int NST = qte_pkg::NST;
  localparam int SQ_N = qte_pkg::SQ_N;
  localparam int NC = qte_pkg::CORDIC_STEPS;
  localparam int SW = qte_pkg::SW;
  localparam int PW = qte_pkg::PW;
  localparam int TW = qte_pkg::TW;
  localparam int RW = qte_pkg::RW;
  localparam int TRW = qte_pkg::TRW;
  localparam int CW = qte_pkg::CW;
  localparam int RNDW = qte_pkg::RNDW;

  logic [NST-1:0] v_r;
  logic en;

  assign en = !v_r[NST-1] || out_chan.ready;
  assign in_chan.ready = en;
  assign out_chan.valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_chan.valid};
    end
  end

  logic signed [PW-1:0] p_xx_r, p_yy_r, p_zz_r, p_ww_r;
  logic signed [PW-1:0] p_wx_r, p_yz_r, p_xz_r, p_wy_r, p_xy_r, p_zw_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xx_r <= PW'(in_chan.quat_x) * PW'(in_chan.quat_x);
      p_yy_r <= PW'(in_chan.quat_y) * PW'(in_chan.quat_y);
      p_zz_r <= PW'(in_chan.quat_z) * PW'(in_chan.quat_z);
      p_ww_r <= PW'(in_chan.quat_w) * PW'(in_chan.quat_w);
      p_wx_r <= PW'(in_chan.quat_w) * PW'(in_chan.quat_x);
      p_yz_r <= PW'(in_chan.quat_y) * PW'(in_chan.quat_z);
      p_xz_r <= PW'(in_chan.quat_x) * PW'(in_chan.quat_z);
      p_wy_r <= PW'(in_chan.quat_w) * PW'(in_chan.quat_y);
      p_xy_r <= PW'(in_chan.quat_x) * PW'(in_chan.quat_y);
      p_zw_r <= PW'(in_chan.quat_z) * PW'(in_chan.quat_w);
    end
  end

  logic signed [SW-1:0] t1_r, ya1_r, xa1_r, yb1_r, xb1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= (SW'(p_wx_r) - SW'(p_yz_r)) <<< 1;
      ya1_r <= (SW'(p_xz_r) + SW'(p_wy_r)) <<< 1;
      xa1_r <= -SW'(p_xx_r) - SW'(p_yy_r) + SW'(p_zz_r) + SW'(p_ww_r);
      yb1_r <= (SW'(p_xy_r) + SW'(p_zw_r)) <<< 1;
      xb1_r <= -SW'(p_xx_r) + SW'(p_yy_r) - SW'(p_zz_r) + SW'(p_ww_r);
    end
  end

  qte_pkg::side_t side2_r;
  logic [RW-1:0] tt2_r;
  logic signed [2*TW-1:0] tt_full;

  assign tt_full = $signed(t1_r[TW-1:0]) * $signed(t1_r[TW-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r.ya <= ya1_r;
      side2_r.xa <= xa1_r;
      side2_r.yb <= yb1_r;
      side2_r.xb <= xb1_r;
      side2_r.t <= t1_r[TW-1:0];
      side2_r.sat <= (t1_r >= qte_pkg::ONE_Q28) || (t1_r <= -qte_pkg::ONE_Q28);
      side2_r.sat_neg <= t1_r[SW-1];
      tt2_r <= tt_full[RW-1:0];
    end
  end

  logic [RW-1:0] sq_rem_r [0:SQ_N];
  logic [SQ_N-1:0] sq_root_r [0:SQ_N];
  qte_pkg::side_t sq_side_r [0:SQ_N];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0] <= qte_pkg::ONE_SQ - tt2_r;
      sq_root_r[0] <= '0;
      sq_side_r[0] <= side2_r;
    end
  end

  for (genvar s = 0; s < SQ_N; s++) begin : g_sqrt
    localparam int B = SQ_N - 1 - s;
    logic [TRW-1:0] trial;
    logic fits;

    assign trial = (TRW'(sq_root_r[s]) << (B + 1)) + (TRW'(1) << (2 * B));
    assign fits = TRW'(sq_rem_r[s]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[s+1] <= fits ? (sq_rem_r[s] - trial[RW-1:0]) : sq_rem_r[s];
        sq_root_r[s+1] <= fits ? (sq_root_r[s] | (SQ_N'(1) << B)) : sq_root_r[s];
        sq_side_r[s+1] <= sq_side_r[s];
      end
    end
  end

  qte_pkg::cord_t cd_r [0:NC][0:2];
  logic [1:0] cs_r [0:NC];
  qte_pkg::side_t sd_end;

  assign sd_end = sq_side_r[SQ_N];

  always_ff @(posedge clk) begin
    if (en) begin
      cd_r[0][0] <= qte_pkg::cord_init(CW'(sd_end.t) <<< qte_pkg::PRE_SH,
                                       CW'(sq_root_r[SQ_N]) <<< qte_pkg::PRE_SH);
      cd_r[0][1] <= qte_pkg::cord_init(CW'(sd_end.ya) <<< qte_pkg::PRE_SH,
                                       CW'(sd_end.xa) <<< qte_pkg::PRE_SH);
      cd_r[0][2] <= qte_pkg::cord_init(CW'(sd_end.yb) <<< qte_pkg::PRE_SH,
                                       CW'(sd_end.xb) <<< qte_pkg::PRE_SH);
      cs_r[0] <= {sd_end.sat, sd_end.sat_neg};
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    for (genvar l = 0; l < 3; l++) begin : g_lane
      qte_pkg::cord_t c_nxt;

      always_comb begin
        logic signed [CW-1:0] xc;
        logic signed [CW-1:0] yc;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xc = cd_r[i][l].x;
        yc = cd_r[i][l].y;
        xs = xc >>> i;
        ys = yc >>> i;
        c_nxt.zero = cd_r[i][l].zero;
        if (yc >= 0) begin
          c_nxt.x = xc + ys;
          c_nxt.y = yc - xs;
          c_nxt.z = cd_r[i][l].z + qte_pkg::atan_q28(i);
        end else begin
          c_nxt.x = xc - ys;
          c_nxt.y = yc + xs;
          c_nxt.z = cd_r[i][l].z - qte_pkg::atan_q28(i);
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          cd_r[i+1][l] <= c_nxt;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs_r[i+1] <= cs_r[i];
      end
    end
  end

  logic signed [RNDW-1:0] ax_nxt, ay_nxt, az_nxt;
  logic signed [qte_pkg::AXW-1:0] ax_r;
  logic signed [qte_pkg::AYW-1:0] ay_r, az_r;

  always_comb begin
    if (cs_r[NC][1]) begin
      ax_nxt = cs_r[NC][0] ? -qte_pkg::HALF_PI_Q13 : qte_pkg::HALF_PI_Q13;
    end else if (cd_r[NC][0].zero) begin
      ax_nxt = '0;
    end else begin
      ax_nxt = qte_pkg::round_q13(cd_r[NC][0].z, qte_pkg::HALF_PI_Q13);
    end
    ay_nxt = cd_r[NC][1].zero ? '0 : qte_pkg::round_q13(cd_r[NC][1].z, qte_pkg::PI_Q13);
    az_nxt = cd_r[NC][2].zero ? '0 : qte_pkg::round_q13(cd_r[NC][2].z, qte_pkg::PI_Q13);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= ax_nxt[qte_pkg::AXW-1:0];
      ay_r <= ay_nxt[qte_pkg::AYW-1:0];
      az_r <= az_nxt[qte_pkg::AYW-1:0];
    end
  end

  assign out_chan.angle_x = ax_r;
  assign out_chan.angle_y = ay_r;
  assign out_chan.angle_z = az_r;

endmodule

`default_nettype wire

>>> rtl/core/qte_checker.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: port checker
// Watches the converter's ports and flags flow control and range errors.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [qte_pkg::AXW-1:0]     angle_x,
  input logic signed [qte_pkg::AYW-1:0]     angle_y,
  input logic signed [qte_pkg::AYW-1:0]     angle_z
);

  // A stalled result transaction must hold its angles.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(angle_x) &&
    $stable(angle_y) && $stable(angle_z))
    else $error("result changed while stalled");

  // An empty or draining output stage always lets a new quaternion in.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked without a stalled result");

  a_range_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (angle_x >= -15'sd12868) && (angle_x <= 15'sd12868))
    else $error("angle_x out of range");

  a_range_yz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (angle_y >= -16'sd25736) && (angle_y <= 16'sd25736) &&
    (angle_z >= -16'sd25736) && (angle_z <= 16'sd25736))
    else $error("angle_y or angle_z out of range");

endmodule

bind quaternion_to_euler_angles_unit qte_checker u_qte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .angle_x   (out_chan.angle_x),
  .angle_y   (out_chan.angle_y),
  .angle_z   (out_chan.angle_z)
);

`default_nettype wire

>>> tb/quaternion_to_euler_angles_unit_test.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles converter testbench
// Drives directed and random quaternions through the converter with bursty
// input and a stalling receiver, and checks every angle transaction against
// a directed row's angles or a bit-accurate fixed-point CORDIC predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quaternion_to_euler_angles_unit_test;

  typedef struct {
    logic signed [15:0] qx, qy, qz, qw;
    bit has_angles;
    logic signed [14:0] ax;
    logic signed [15:0] ay, az;
  } quat_row_t;

  typedef struct {
    logic signed [14:0] ax;
    logic signed [15:0] ay, az;
  } euler_t;

  localparam longint ONE_Q = 64'sd268435456;
  localparam longint PI_Q = 64'sd843314857;
  localparam int TILT_LIM = 12868;
  localparam int SPIN_LIM = 25736;
  localparam longint ATAN_STEP [24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

  logic clk;
  logic rst_n;
  bit send_on;
  bit recv_on;
  int mismatches;
  euler_t pending_angles[$];
  quat_row_t directed_rows[$];

  qte_quat_if in_chan();
  qte_angle_if out_chan();

  quaternion_to_euler_angles_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL quaternion_to_euler_angles_unit");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    if (v < 0) begin
      return -1 - ((-1 - v) >>> s);
    end
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint acc;
    longint xs;
    longint ys;
    acc = 0;
    if (xv == 0 && yv == 0) begin
      return 0;
    end
    if (xv < 0) begin
      acc = (yv >= 0) ? PI_Q : -PI_Q;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < qte_pkg::ANGLE_ITERATIONS && i < 24; i++) begin
      xs = floor_shift(xv, i);
      ys = floor_shift(yv, i);
      if (yv >= 0) begin
        xv += ys;
        yv -= xs;
        acc += ATAN_STEP[i];
      end else begin
        xv -= ys;
        yv += xs;
        acc -= ATAN_STEP[i];
      end
    end
    return acc;
  endfunction

  function automatic longint to_radians_q13(longint a, longint lim);
    longint r;
    r = floor_shift(a + 16384, 15);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t predict_angles(logic signed [15:0] qx, logic signed [15:0] qy,
                                            logic signed [15:0] qz, logic signed [15:0] qw);
    euler_t e;
    longint x, y, z, w, t, c, ax, ay, az;
    longint unsigned rem;
    x = longint'(qx);
    y = longint'(qy);
    z = longint'(qz);
    w = longint'(qw);
    t = 2 * (w * x - y * z);
    if (t >= ONE_Q) begin
      ax = TILT_LIM;
    end else if (t <= -ONE_Q) begin
      ax = -TILT_LIM;
    end else begin
      rem = longint'(ONE_Q * ONE_Q) - longint'(t * t);
      c = root_floor(rem);
      ax = to_radians_q13(vector_angle(t * 65536, c * 65536), TILT_LIM);
    end
    ay = to_radians_q13(vector_angle(2 * (x * z + w * y) * 65536,
                                     (-x * x - y * y + z * z + w * w) * 65536), SPIN_LIM);
    az = to_radians_q13(vector_angle(2 * (x * y + z * w) * 65536,
                                     (-x * x + y * y - z * z + w * w) * 65536), SPIN_LIM);
    e.ax = ax[14:0];
    e.ay = ay[15:0];
    e.az = az[15:0];
    return e;
  endfunction

  task automatic add_row(int qx, int qy, int qz, int qw, bit known = 0,
                         int ax = 0, int ay = 0, int az = 0);
    quat_row_t r;
    r.qx = 16'(qx);
    r.qy = 16'(qy);
    r.qz = 16'(qz);
    r.qw = 16'(qw);
    r.has_angles = known;
    r.ax = 15'(ax);
    r.ay = 16'(ay);
    r.az = 16'(az);
    directed_rows.push_back(r);
  endtask

  task automatic send_quat(quat_row_t r);
    euler_t e;
    if (!send_on) begin
      in_chan.valid <= 1'b0;
      while (!send_on) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.quat_x <= r.qx;
    in_chan.quat_y <= r.qy;
    in_chan.quat_z <= r.qz;
    in_chan.quat_w <= r.qw;
    do @(posedge clk); while (!in_chan.ready);
    if (r.has_angles) begin
      e.ax = r.ax;
      e.ay = r.ay;
      e.az = r.az;
    end else begin
      e = predict_angles(r.qx, r.qy, r.qz, r.qw);
    end
    pending_angles.push_back(e);
  endtask

  function automatic int random_component();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16384 : -16384;
      1: return int'($urandom_range(0, 65535)) - 32768;
      2: return 0;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  // Builds a near-unit quaternion by scaling a random direction.
  task automatic random_unit_row(output quat_row_t r);
    int v[4];
    longint n2;
    longint n;
    do begin
      n2 = 0;
      for (int i = 0; i < 4; i++) begin
        v[i] = int'($urandom_range(0, 32768)) - 16384;
        n2 += longint'(v[i]) * v[i];
      end
    end while (n2 < 64'd1000000);
    n = root_floor(n2);
    r.qx = 16'((longint'(v[0]) * 16384) / n);
    r.qy = 16'((longint'(v[1]) * 16384) / n);
    r.qz = 16'((longint'(v[2]) * 16384) / n);
    r.qw = 16'((longint'(v[3]) * 16384) / n);
    r.has_angles = 0;
  endtask

  always @(posedge clk) begin
    if (out_chan.valid && out_chan.ready) begin
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected angle transaction: x=%0d y=%0d z=%0d",
                   out_chan.angle_x, out_chan.angle_y, out_chan.angle_z);
        end
      end else begin
        euler_t e;
        e = pending_angles.pop_front();
        if (out_chan.angle_x !== e.ax || out_chan.angle_y !== e.ay ||
            out_chan.angle_z !== e.az) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Angle mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                     e.ax, e.ay, e.az, out_chan.angle_x, out_chan.angle_y,
                     out_chan.angle_z);
          end
        end
      end
    end
  end

  // Receiver stalls in runs with its own rhythm.
  initial begin
    int span;
    recv_on = 1'b1;
    out_chan.ready = 1'b0;
    @(posedge clk);
    forever begin
      span = $urandom_range(1, 40);
      recv_on = ($urandom_range(0, 3) != 0);
      repeat (span) begin
        out_chan.ready <= recv_on ? 1'b1 : ($urandom_range(0, 3) == 0);
        @(posedge clk);
      end
    end
  end

  // Sender works in bursts separated by random gaps.
  initial begin
    int span;
    send_on = 1'b1;
    forever begin
      @(posedge clk);
      span = $urandom_range(1, 30);
      send_on = 1'b1;
      repeat (span) @(posedge clk);
      if ($urandom_range(0, 2) == 0) begin
        send_on = 1'b1;
      end else begin
        send_on = 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    quat_row_t r;
    int guard;
    mismatches = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.quat_x = '0;
    in_chan.quat_y = '0;
    in_chan.quat_z = '0;
    in_chan.quat_w = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(0, 0, 0, 16384);
    add_row(0, 0, 0, 0);
    add_row(11585, 0, 0, 11585);
    add_row(-11585, 0, 0, 11585);
    add_row(16384, 0, 0, 16384, 1, TILT_LIM, 0, 0);
    add_row(16384, 0, 0, -16384, 1, -TILT_LIM, 0, 0);
    add_row(0, 16384, 0, 0);
    add_row(0, 0, 16384, 0);
    add_row(16384, 0, 0, 0);
    add_row(-16384, -16384, -16384, -16384);
    add_row(16384, 16384, 16384, 16384);
    add_row(32767, 32767, 32767, 32767);
    add_row(-32768, -32768, -32768, -32768);
    add_row(-32768, 32767, -32768, 32767);
    add_row(0, 11585, 0, 11585);
    add_row(0, 0, 11585, 11585);
    add_row(0, -16384, 0, 1);
    add_row(8192, 8192, 8192, 8192);
    add_row(8192, -8192, 8192, -8192);
    add_row(-21846, 21845, 1, -1);
    foreach (directed_rows[i]) send_quat(directed_rows[i]);

    for (int n = 0; n < 400; n++) begin
      if (n == 200) begin
        in_chan.valid <= 1'b0;
        guard = 0;
        while (pending_angles.size() != 0 && guard < 100000) begin
          @(posedge clk);
          guard++;
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        random_unit_row(r);
      end else begin
        r.qx = 16'(random_component());
        r.qy = 16'(random_component());
        r.qz = 16'(random_component());
        r.qw = 16'(random_component());
        r.has_angles = 0;
      end
      send_quat(r);
    end
    in_chan.valid <= 1'b0;

    guard = 0;
    while (pending_angles.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_angles.size() == 0) begin
      $display("PASS quaternion_to_euler_angles_unit");
    end else begin
      $display("FAIL quaternion_to_euler_angles_unit");
    end
    $finish;
  end
endmodule
